[rtl/gcmgh_pkg.sv]
package gcmgh_pkg;

    // One 128-bit GCM block, byte 0 in the top bits.
    typedef logic [127:0] t_blk;

    // Word kind carried on the input tuser bit.
    typedef enum logic {
        CMD_ABSORB = 1'b0,
        CMD_FINISH = 1'b1
    } t_cmd;

    // Register map, one 64-bit register every eight bytes.
    typedef enum logic [1:0] {
        CFG_HKEY_HI = 2'd0,
        CFG_HKEY_LO = 2'd1,
        CFG_MASK_HI = 2'd2,
        CFG_MASK_LO = 2'd3
    } t_cfg_reg;

    // Bit 127 of a block holds the coefficient of x^0 in GCM order, so the
    // polynomial view of a block is its bit reversal.
    function automatic t_blk reflect(input t_blk v);
        t_blk r;
        for (int k = 0; k < 128; k++) begin
            r[k] = v[127 - k];
        end
        return r;
    endfunction

endpackage

[rtl/gcmgh_gfmul.sv]
module gcmgh_gfmul (
    input  logic [127:0] i_a,
    input  logic [127:0] i_b,
    output logic [127:0] o_p
);
    import gcmgh_pkg::*;

    t_blk         a_r;
    t_blk         b_r;
    logic [254:0] prod;
    logic [133:0] fold1;
    logic [127:0] fold2;
    logic [127:0] red;

    assign a_r = reflect(i_a);
    assign b_r = reflect(i_b);

    // Carry-less product: each partial product depends on one bit of a only.
    always_comb begin
        prod = '0;
        for (int i = 0; i < 128; i++) begin
            if (a_r[i]) begin
                prod = prod ^ ({127'b0, b_r} << i);
            end
        end
    end

    // Reduce by x^128 = x^7 + x^2 + x + 1; the first fold leaves at most
    // six bits above degree 127, which the second fold clears.
    assign fold1 = {7'b0, prod[254:128]} ^ {6'b0, prod[254:128], 1'b0}
                 ^ {5'b0, prod[254:128], 2'b0} ^ {prod[254:128], 7'b0};
    assign fold2 = 128'(fold1[133:128]) ^ (128'(fold1[133:128]) << 1)
                 ^ (128'(fold1[133:128]) << 2) ^ (128'(fold1[133:128]) << 7);
    assign red   = prod[127:0] ^ fold1[127:0] ^ fold2;

    assign o_p = reflect(red);

endmodule

[rtl/gcm_ghash_tag_engine.sv]
// GHASH tag engine for AES-GCM. Ciphertext words arrive on the s_axis side
// with tuser low: tdata carries the two big-endian block halves and a count of
// valid bytes (1 to 16, larger counts act as 16, a count of zero drops the
// word), and bytes beyond the count are zeroed before the block is folded into
// the accumulator as acc = (acc xor block) * H. A word with tuser high
// finishes the message: it absorbs the length block 0 || bits(C), emits
// acc xor E_K(J0) as the tag on m_axis, and clears the accumulator and the
// byte total for the next message. The byte total saturates at
// 2^LENGTH_BITS - 1. H and E_K(J0) are written over the APB port, four 64-bit
// registers at byte addresses 0, 8, 16 and 24; the user must write them only
// while no word is in flight, as the engine itself does not enforce it. The
// engine takes one word every cycle while not stalled; a finish word is held
// in the input register and its tag is then registered into the output
// register. The accumulator feedback loop closes through one full
// combinational GF(2^128) multiplier between the input register and the
// accumulator. The input side stalls only while a tag waits on m_axis and a
// second finish word sits in the input register.
module gcm_ghash_tag_engine #(
    parameter int LENGTH_BITS = 36
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [63:0] block_hi, [127:64] block_lo, [132:128] byte_count, rest zero
    input  logic [135:0] s_axis_tdata,
    // [0] command
    input  logic         s_axis_tuser,
    // Tag stream.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] tag_hi, [127:64] tag_lo
    output logic [127:0] m_axis_tdata,
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import gcmgh_pkg::*;

    localparam int TotW = LENGTH_BITS + 1;

    // Configuration registers.
    logic [63:0] r_hkey_hi, r_hkey_lo, r_mask_hi, r_mask_lo;
    logic        cfg_wr;
    t_cfg_reg    cfg_sel;

    // Input register stage.
    logic        r_vld;
    t_cmd        r_cmd;
    t_blk        r_x;
    logic [4:0]  r_cnt;

    // Accumulator state.
    t_blk                   r_acc;
    logic [LENGTH_BITS-1:0] r_total;

    // Output register.
    logic        r_ovld;
    t_blk        r_tag;

    logic        stall;
    logic        in_acc;
    logic        take;
    t_cmd        in_cmd;
    logic [4:0]  in_cnt;
    logic [4:0]  cnt_cl;
    t_blk        in_blk;
    t_blk        keep;
    logic        step;
    logic        load_tag;
    t_blk        x_sel;
    t_blk        mul_p;
    logic [TotW-1:0] sum;
    logic [LENGTH_BITS-1:0] n_total;

    // ------------------------------------------------------------------
    // Configuration port: one 64-bit register per eight-byte slot.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_sel = t_cfg_reg'(paddr[4:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hkey_hi <= '0;
            r_hkey_lo <= '0;
            r_mask_hi <= '0;
            r_mask_lo <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                CFG_HKEY_HI: r_hkey_hi <= pwdata;
                CFG_HKEY_LO: r_hkey_lo <= pwdata;
                CFG_MASK_HI: r_mask_hi <= pwdata;
                CFG_MASK_LO: r_mask_lo <= pwdata;
                default:     r_hkey_hi <= r_hkey_hi;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            CFG_HKEY_HI: prdata = r_hkey_hi;
            CFG_HKEY_LO: prdata = r_hkey_lo;
            CFG_MASK_HI: prdata = r_mask_hi;
            CFG_MASK_LO: prdata = r_mask_lo;
            default:     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input side: clamp the count and zero the bytes beyond it.
    // ------------------------------------------------------------------
    // The pipe only halts when a finish word needs the output register while
    // an earlier tag is still waiting there.
    assign stall         = r_vld & (r_cmd == CMD_FINISH) & r_ovld & ~m_axis_tready;
    assign s_axis_tready = ~stall;
    assign in_acc        = s_axis_tvalid & s_axis_tready;

    assign in_cmd = t_cmd'(s_axis_tuser);
    assign in_cnt = s_axis_tdata[132:128];
    assign cnt_cl = (in_cnt > 5'd16) ? 5'd16 : in_cnt;
    assign in_blk = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

    always_comb begin
        for (int j = 0; j < 16; j++) begin
            keep[127 - 8*j -: 8] = (5'(j) < cnt_cl) ? 8'hFF : 8'h00;
        end
    end

    // An absorb word with no valid bytes leaves no trace.
    assign take = in_acc & ((in_cmd == CMD_FINISH) | (in_cnt != 5'd0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!stall) begin
            r_vld <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= in_cmd;
            r_x   <= in_blk & keep;
            r_cnt <= cnt_cl;
        end
    end

    // ------------------------------------------------------------------
    // Accumulator update: one GF(2^128) multiply per cycle while not stalled.
    // ------------------------------------------------------------------
    assign step     = r_vld & ~stall;
    assign load_tag = step & (r_cmd == CMD_FINISH);

    // A finish word absorbs the length block: zero upper half, bit count low.
    assign x_sel = (r_cmd == CMD_FINISH) ? {64'b0, 64'({r_total, 3'b000})} : r_x;

    gcmgh_gfmul u_gfmul (
        .i_a (r_acc ^ x_sel),
        .i_b ({r_hkey_hi, r_hkey_lo}),
        .o_p (mul_p)
    );

    assign sum     = {1'b0, r_total} + TotW'(r_cnt);
    assign n_total = sum[TotW-1] ? '1 : sum[LENGTH_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_total <= '0;
        end else if (step) begin
            if (r_cmd == CMD_FINISH) begin
                r_acc   <= '0;
                r_total <= '0;
            end else begin
                r_acc   <= mul_p;
                r_total <= n_total;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (load_tag) begin
            r_ovld <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_tag) begin
            r_tag <= mul_p ^ {r_mask_hi, r_mask_lo};
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {r_tag[63:0], r_tag[127:64]};

endmodule

[rtl/gcmgh_checker.sv]
module gcmgh_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic         pready
);
    import gcmgh_pkg::*;

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

    // With no tag waiting, the input side must never push back.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output register");

    // A taken finish word passes the input register and then puts a tag on the output.
    a_finish_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_FINISH))
        |=> ##1 m_axis_tvalid)
        else $error("finish word produced no tag");

    // A waiting tag holds until it is taken.
    a_tag_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("tag changed while stalled");

endmodule

bind gcm_ghash_tag_engine gcmgh_checker u_gcmgh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);
